// ----- design/hcbp_pkg.sv -----
package hcbp_pkg;

    localparam int VALUE_W = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int FILL_W  = 3;
    localparam int MAX_OUT = 4;
    localparam int CNT_W   = 3;
    localparam int WIN_W   = BYTE_W + VALUE_W;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_FLUSH  = 2'd2
    } t_kind;

    // one item leaving the table stage toward the packer
    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   length;
    } t_pack_req;

endpackage

// ----- design/hcbp_table.sv -----
module hcbp_table
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = 32,
    parameter int SYMBOLS       = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic               i_rd_en,
    input  logic [7:0]         i_symbol,
    input  logic [VALUE_W-1:0] i_code_value,
    input  logic [LEN_W-1:0]   i_code_length,
    output logic [VALUE_W-1:0] o_rd_value,
    output logic [LEN_W-1:0]   o_rd_length
);

    localparam int IDX_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int LEN_CAP = (MAX_CODE_BITS < VALUE_W) ? MAX_CODE_BITS : VALUE_W;

    logic [VALUE_W+LEN_W-1:0] r_mem [SYMBOLS];
    logic [SYMBOLS-1:0]       r_entry_valid;
    logic [VALUE_W+LEN_W-1:0] r_rd_data;
    logic                     r_rd_hit;

    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] sat_length;

    assign in_range   = {1'b0, i_symbol} < 9'(SYMBOLS);
    assign idx        = i_symbol[IDX_W-1:0];
    assign sat_length = (int'(i_code_length) > LEN_CAP) ? LEN_W'(LEN_CAP) : i_code_length;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && in_range) begin
            r_mem[idx] <= {i_code_value, sat_length};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[idx];
        end
    end

    // per-entry valid bits stand in for clearing the table at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_rd_hit      <= 1'b0;
        end else begin
            if (i_wr_en && in_range) begin
                r_entry_valid[idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= in_range && r_entry_valid[idx];
            end
        end
    end

    assign o_rd_value  = r_rd_data[VALUE_W+LEN_W-1:LEN_W];
    assign o_rd_length = r_rd_hit ? r_rd_data[LEN_W-1:0] : '0;

endmodule

// ----- design/hcbp_packer.sv -----
module hcbp_packer
    import hcbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pack_req   i_req,
    output logic        o_take,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_is_flush,
    output logic [2:0]  o_tail_bits,
    output logic        o_is_last
);

    logic [BYTE_W-1:0]        r_partial;
    logic [FILL_W-1:0]        r_filled;
    logic [MAX_OUT*BYTE_W-1:0] r_obuf;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_flush;
    logic                     r_bvalid;
    logic [FILL_W-1:0]        r_tail;

    logic                     out_acc;
    logic                     buf_free;
    logic [VALUE_W:0]         mask;
    logic [VALUE_W-1:0]       masked;
    logic [LEN_W-1:0]         total;
    logic [LEN_W-1:0]         sh;
    logic [CNT_W-1:0]         nbytes;
    logic [WIN_W-1:0]         win;
    logic [WIN_W-1:0]         rest;

    assign out_acc  = o_out_valid && i_out_ready;
    assign buf_free = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_out_ready);
    assign o_take   = i_req.valid && (buf_free ||
                      !(i_req.kind == KIND_ENCODE || i_req.kind == KIND_FLUSH));

    // line up pending bits and the new code msb-first in one window
    always_comb begin
        mask   = ((VALUE_W+1)'(1) << i_req.length) - (VALUE_W+1)'(1);
        masked = i_req.value & mask[VALUE_W-1:0];
        total  = LEN_W'(r_filled) + i_req.length;
        sh     = LEN_W'(WIN_W) - LEN_W'(r_filled) - i_req.length;
        nbytes = total[LEN_W-1:3];
        win    = {r_partial, {VALUE_W{1'b0}}} | ({{BYTE_W{1'b0}}, masked} << sh);
        rest   = win << {nbytes, 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_filled  <= '0;
            r_cnt     <= '0;
            r_flush   <= 1'b0;
            r_bvalid  <= 1'b0;
            r_tail    <= '0;
        end else if (o_take && i_req.kind == KIND_ENCODE) begin
            r_partial <= rest[WIN_W-1:WIN_W-BYTE_W];
            r_filled  <= total[FILL_W-1:0];
            r_obuf    <= win[WIN_W-1:BYTE_W];
            r_cnt     <= nbytes;
            r_flush   <= 1'b0;
            r_bvalid  <= 1'b1;
            r_tail    <= '0;
        end else if (o_take && i_req.kind == KIND_FLUSH) begin
            r_partial <= '0;
            r_filled  <= '0;
            r_obuf    <= {r_partial, {(MAX_OUT-1)*BYTE_W{1'b0}}};
            r_cnt     <= CNT_W'(1);
            r_flush   <= 1'b1;
            r_bvalid  <= (r_filled != '0);
            r_tail    <= r_filled;
        end else if (out_acc) begin
            r_obuf <= r_obuf << BYTE_W;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_out_valid  = (r_cnt != '0);
    assign o_out_byte   = r_obuf[MAX_OUT*BYTE_W-1 -: BYTE_W];
    assign o_byte_valid = r_bvalid;
    assign o_is_flush   = r_flush;
    assign o_tail_bits  = r_tail;
    assign o_is_last    = (r_cnt == CNT_W'(1));

endmodule

// ----- design/huffman_code_bit_packer.sv -----
// huffman code bit packer
// input channel (i_in_valid / o_in_ready) takes one request per cycle while ready:
// kind 0 writes a table entry, kind 1 encodes a symbol, kind 2 flushes the
// partial byte, kind 3 is dropped. output channel (o_out_valid / i_out_ready)
// carries one byte per result; o_is_last marks the final result of a request.
// the table read is registered on acceptance, and the packer loads the output
// buffer when it takes the request from the table stage, so a result passes
// the table stage and the output buffer before it can be taken.
// throughput: one request per cycle while each yields at most one result and the
// receiver is ready; an encode that completes n bytes holds the 4-byte output
// buffer until all n are taken, one byte a cycle while ready; that is the worst case.
// writes and dropped kinds never wait on the output side; an encode or a flush
// waits until the buffer is empty or its last byte is taken in the same cycle.
// reset clears the pending bits, the pipeline and the table valid bits at once,
// so every entry reads as an empty code; there is no clearing pass.
// when the receiver stalls, the current result holds, one more request waits in
// the table stage and o_in_ready drops until the buffer frees up.
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = 32,
    parameter int SYMBOLS       = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_symbol,
    input  logic [31:0] i_code_value,
    input  logic [5:0]  i_code_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_is_flush,
    output logic [2:0]  o_tail_bits,
    output logic        o_is_last
);

    logic               r_s1_valid;
    t_kind              r_s1_kind;
    logic               in_acc;
    logic               take;
    logic [VALUE_W-1:0] rd_value;
    logic [LEN_W-1:0]   rd_length;
    t_pack_req          req;

    assign o_in_ready = !r_s1_valid || take;
    assign in_acc     = i_in_valid && o_in_ready;

    hcbp_table #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .SYMBOLS       (SYMBOLS)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (in_acc && i_kind == KIND_WRITE),
        .i_rd_en       (in_acc),
        .i_symbol      (i_symbol),
        .i_code_value  (i_code_value),
        .i_code_length (i_code_length),
        .o_rd_value    (rd_value),
        .o_rd_length   (rd_length)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_kind  <= KIND_WRITE;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            r_s1_kind  <= t_kind'(i_kind);
        end else if (take) begin
            r_s1_valid <= 1'b0;
        end
    end

    assign req = '{valid: r_s1_valid, kind: r_s1_kind, value: rd_value, length: rd_length};

    hcbp_packer u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_is_flush   (o_is_flush),
        .o_tail_bits  (o_tail_bits),
        .o_is_last    (o_is_last)
    );

`ifndef SYNTHESIS
    a_flush_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_flush |-> o_is_last)
        else $error("flush result not marked last");

    a_encode_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_flush |-> o_byte_valid && o_tail_bits == 3'd0)
        else $error("encode result with bad flags");

    a_stage_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !take |=> r_s1_valid && $stable(r_s1_kind))
        else $error("held table stage request lost");
`endif

endmodule
